// ===== sv/cbs_pkg.sv =====
package cbs_pkg;

   localparam int PATTERN_LEN = 256;
   localparam int PTR_W       = $clog2(PATTERN_LEN);

   localparam int PHASE_W = 5;
   localparam int VPC_W   = 2;
   localparam int CNT_W   = 32;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 2;

   localparam logic [PHASE_W-1:0] PHASE_AFIB_BASE = PHASE_W'(5);
   localparam logic [PHASE_W-1:0] PHASE_VPC_GAP   = PHASE_W'(6);
   localparam logic [PHASE_W-1:0] PHASE_SINUS     = PHASE_W'(9);
   localparam logic [PHASE_W-1:0] PHASE_END_SHORT = PHASE_W'(13);
   localparam logic [PHASE_W-1:0] PHASE_END_MID   = PHASE_W'(16);
   localparam logic [PHASE_W-1:0] PHASE_END_LONG  = PHASE_W'(19);

   typedef enum logic [1:0] {
      CMD_PULSE   = 2'd0,
      CMD_BREATH  = 2'd1,
      CMD_PATTERN = 2'd2,
      CMD_SPARE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_SINUS  = 2'd1,
      EV_VPC    = 2'd2,
      EV_BREATH = 2'd3
   } event_type;

   typedef enum logic [CSR_AW-1:0] {
      CSR_PULSE_ACTIVE  = 3'd0,
      CSR_BREATH_ACTIVE = 3'd1,
      CSR_VPC_ENABLE    = 3'd2,
      CSR_VPC_RUN_LEN   = 3'd3,
      CSR_AFIB_MODE     = 3'd4
   } csr_index_type;

   localparam logic [VPC_W-1:0] RUN_LEN_MID  = VPC_W'(2);
   localparam logic [VPC_W-1:0] RUN_LEN_LONG = VPC_W'(3);

endpackage

// ===== sv/cardiac_beat_sequencer_core.sv =====
// Heart and breath rhythm sequencer. One beat on req_ gives exactly one beat on
// rsp_, and a beat is taken every cycle while the result register is empty or
// being drained: all work is one pass from the accepted beat to the result
// register. Pulse ticks count down the phase and, at expiry, emit a sinus or a
// premature beat; breath ticks count breaths; pattern writes fill the 1-bit
// store. The store entry for the next sinus cycle is prefetched into a register,
// with writes to that entry forwarded, so no tick waits on it.
// Configuration must be written only while no beat is in flight.
module cardiac_beat_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] cpr_running, [1] shock_active, [5:2] afib_offset, [13:6] pattern_slot,
   // [14] pattern_bit, [15] zero
   input  logic [15:0] req_tdata,
   // [1:0] cmd
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] sinus_total, [63:32] vpc_total, [95:64] breath_total
   output logic [95:0] rsp_tdata,
   // [1:0] event_res
   output logic [1:0]  rsp_tuser,
   input  logic                       csr_we,
   input  logic [cbs_pkg::CSR_AW-1:0] csr_addr,
   input  logic [cbs_pkg::CSR_DW-1:0] csr_wdata
);

   logic                         pulse_active_ff;
   logic                         breath_active_ff;
   logic                         vpc_enable_ff;
   logic [cbs_pkg::VPC_W-1:0]    vpc_run_len_ff;
   logic                         afib_mode_ff;

   logic [cbs_pkg::PHASE_W-1:0]  phase_ff, phase_in;
   logic [cbs_pkg::VPC_W-1:0]    vpc_left_ff, vpc_left_in;
   logic [cbs_pkg::PTR_W-1:0]    ptr_ff, ptr_in;
   logic [cbs_pkg::CNT_W-1:0]    sinus_ff, sinus_in;
   logic [cbs_pkg::CNT_W-1:0]    vpc_cnt_ff, vpc_cnt_in;
   logic [cbs_pkg::CNT_W-1:0]    breath_ff, breath_in;
   logic                         peek_ff;

   logic                         rsp_valid_ff;
   cbs_pkg::event_type           ev_ff, ev_in;

   logic                         pat_mem [cbs_pkg::PATTERN_LEN];
   logic [cbs_pkg::PATTERN_LEN-1:0] pat_vld_ff;

   logic                         accept;
   cbs_pkg::cmd_type             cmd;
   logic                         cpr;
   logic                         shock;
   logic [3:0]                   offset;
   logic [7:0]                   slot;
   logic                         pbit;
   logic                         wr_en;
   logic [cbs_pkg::PTR_W-1:0]    wr_addr;
   logic [cbs_pkg::PTR_W-1:0]    rd_addr;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign cmd    = cbs_pkg::cmd_type'(req_tuser);
   assign cpr    = req_tdata[0];
   assign shock  = req_tdata[1];
   assign offset = req_tdata[5:2];
   assign slot   = req_tdata[13:6];
   assign pbit   = req_tdata[14];

   assign wr_en   = accept && (cmd == cbs_pkg::CMD_PATTERN)
                    && (32'(slot) < cbs_pkg::PATTERN_LEN);
   assign wr_addr = cbs_pkg::PTR_W'(slot);
   assign rd_addr = (32'(ptr_in) == cbs_pkg::PATTERN_LEN - 1) ?
                    '0 : ptr_in + cbs_pkg::PTR_W'(1);

   always_comb begin
      phase_in    = phase_ff;
      vpc_left_in = vpc_left_ff;
      ptr_in      = ptr_ff;
      sinus_in    = sinus_ff;
      vpc_cnt_in  = vpc_cnt_ff;
      breath_in   = breath_ff;
      ev_in       = cbs_pkg::EV_NONE;
      if (accept) begin
         case (cmd)
            cbs_pkg::CMD_PULSE: begin
               if (!cpr && !shock && pulse_active_ff) begin
                  if (phase_ff != '0) begin
                     phase_in = phase_ff - cbs_pkg::PHASE_W'(1);
                  end else if (vpc_left_ff != '0) begin
                     ev_in       = cbs_pkg::EV_VPC;
                     vpc_cnt_in  = vpc_cnt_ff + cbs_pkg::CNT_W'(1);
                     vpc_left_in = vpc_left_ff - cbs_pkg::VPC_W'(1);
                     if (vpc_left_ff != cbs_pkg::VPC_W'(1)) begin
                        phase_in = cbs_pkg::PHASE_VPC_GAP;
                     end else if (vpc_run_len_ff == cbs_pkg::RUN_LEN_MID) begin
                        phase_in = cbs_pkg::PHASE_END_MID;
                     end else if (vpc_run_len_ff == cbs_pkg::RUN_LEN_LONG) begin
                        phase_in = cbs_pkg::PHASE_END_LONG;
                     end else begin
                        phase_in = cbs_pkg::PHASE_END_SHORT;
                     end
                  end else begin
                     ev_in    = cbs_pkg::EV_SINUS;
                     sinus_in = sinus_ff + cbs_pkg::CNT_W'(1);
                     if (afib_mode_ff) begin
                        phase_in = cbs_pkg::PHASE_AFIB_BASE
                                   + cbs_pkg::PHASE_W'(offset);
                     end else if (vpc_enable_ff) begin
                        ptr_in = (32'(ptr_ff) == cbs_pkg::PATTERN_LEN - 1) ?
                                 '0 : ptr_ff + cbs_pkg::PTR_W'(1);
                        if (peek_ff) begin
                           vpc_left_in = vpc_run_len_ff;
                           phase_in    = cbs_pkg::PHASE_VPC_GAP;
                        end else begin
                           phase_in = cbs_pkg::PHASE_SINUS;
                        end
                     end else begin
                        phase_in = cbs_pkg::PHASE_SINUS;
                     end
                  end
               end
            end
            cbs_pkg::CMD_BREATH: begin
               if (!cpr && breath_active_ff) begin
                  ev_in     = cbs_pkg::EV_BREATH;
                  breath_in = breath_ff + cbs_pkg::CNT_W'(1);
               end
            end
            default: begin
               ev_in = cbs_pkg::EV_NONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_active_ff  <= 1'b0;
         breath_active_ff <= 1'b0;
         vpc_enable_ff    <= 1'b0;
         vpc_run_len_ff   <= '0;
         afib_mode_ff     <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            cbs_pkg::CSR_PULSE_ACTIVE:  pulse_active_ff  <= csr_wdata[0];
            cbs_pkg::CSR_BREATH_ACTIVE: breath_active_ff <= csr_wdata[0];
            cbs_pkg::CSR_VPC_ENABLE:    vpc_enable_ff    <= csr_wdata[0];
            cbs_pkg::CSR_VPC_RUN_LEN:   vpc_run_len_ff   <= csr_wdata[cbs_pkg::VPC_W-1:0];
            cbs_pkg::CSR_AFIB_MODE:     afib_mode_ff     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         vpc_left_ff  <= '0;
         ptr_ff       <= '0;
         sinus_ff     <= '0;
         vpc_cnt_ff   <= '0;
         breath_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         ev_ff        <= cbs_pkg::EV_NONE;
      end else begin
         phase_ff    <= phase_in;
         vpc_left_ff <= vpc_left_in;
         ptr_ff      <= ptr_in;
         sinus_ff    <= sinus_in;
         vpc_cnt_ff  <= vpc_cnt_in;
         breath_ff   <= breath_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
            ev_ff        <= ev_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // prefetch the entry after the pointer, forwarding a write to it
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_vld_ff <= '0;
         peek_ff    <= 1'b0;
      end else begin
         if (wr_en) begin
            pat_vld_ff[wr_addr] <= 1'b1;
         end
         if (wr_en && (wr_addr == rd_addr)) begin
            peek_ff <= pbit;
         end else begin
            peek_ff <= pat_vld_ff[rd_addr] && pat_mem[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pat_mem[wr_addr] <= pbit;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = ev_ff;
   assign rsp_tdata  = {breath_ff, vpc_cnt_ff, sinus_ff};

endmodule

// ===== test/cardiac_beat_sequencer_core_tb.sv =====
module cardiac_beat_sequencer_core_tb;

   localparam int CYCLE_LIMIT = 500000;

   typedef struct {
      cbs_pkg::event_type        ev;
      logic [cbs_pkg::CNT_W-1:0] sinus;
      logic [cbs_pkg::CNT_W-1:0] vpc;
      logic [cbs_pkg::CNT_W-1:0] breath;
   } rhythm_result_type;

   class rhythm_scoreboard;
      logic                          pulse_on;
      logic                          breath_on;
      logic                          vpc_on;
      logic [cbs_pkg::VPC_W-1:0]     run_len;
      logic                          afib_on;
      logic [cbs_pkg::PHASE_W-1:0]   phase_left;
      logic [cbs_pkg::VPC_W-1:0]     vpc_pending;
      logic [cbs_pkg::PTR_W-1:0]     ptr;
      logic                          store [cbs_pkg::PATTERN_LEN];
      logic [cbs_pkg::CNT_W-1:0]     sinus_cnt;
      logic [cbs_pkg::CNT_W-1:0]     vpc_cnt;
      logic [cbs_pkg::CNT_W-1:0]     breath_cnt;
      rhythm_result_type             pending_q [$];
      int                            mismatches;

      function new();
         pulse_on    = 1'b0;
         breath_on   = 1'b0;
         vpc_on      = 1'b0;
         run_len     = '0;
         afib_on     = 1'b0;
         phase_left  = '0;
         vpc_pending = '0;
         ptr         = '0;
         sinus_cnt   = '0;
         vpc_cnt     = '0;
         breath_cnt  = '0;
         mismatches  = 0;
         foreach (store[i]) store[i] = 1'b0;
      endfunction

      function void set_reg(cbs_pkg::csr_index_type idx, logic [cbs_pkg::CSR_DW-1:0] val);
         case (idx)
            cbs_pkg::CSR_PULSE_ACTIVE:  pulse_on  = val[0];
            cbs_pkg::CSR_BREATH_ACTIVE: breath_on = val[0];
            cbs_pkg::CSR_VPC_ENABLE:    vpc_on    = val[0];
            cbs_pkg::CSR_VPC_RUN_LEN:   run_len   = val[cbs_pkg::VPC_W-1:0];
            cbs_pkg::CSR_AFIB_MODE:     afib_on   = val[0];
            default: ;
         endcase
      endfunction

      function logic [cbs_pkg::PTR_W-1:0] next_slot();
         return (int'(ptr) == cbs_pkg::PATTERN_LEN - 1) ? '0 : ptr + 1'b1;
      endfunction

      function cbs_pkg::event_type pulse_tick(logic [3:0] offset);
         if (!pulse_on) return cbs_pkg::EV_NONE;
         if (phase_left != '0) begin
            phase_left = phase_left - 1'b1;
            return cbs_pkg::EV_NONE;
         end
         if (vpc_pending != '0) begin
            vpc_cnt     = vpc_cnt + 1'b1;
            vpc_pending = vpc_pending - 1'b1;
            if (vpc_pending != '0) phase_left = cbs_pkg::PHASE_VPC_GAP;
            else if (run_len == cbs_pkg::RUN_LEN_MID) phase_left = cbs_pkg::PHASE_END_MID;
            else if (run_len == cbs_pkg::RUN_LEN_LONG) phase_left = cbs_pkg::PHASE_END_LONG;
            else phase_left = cbs_pkg::PHASE_END_SHORT;
            return cbs_pkg::EV_VPC;
         end
         sinus_cnt = sinus_cnt + 1'b1;
         if (afib_on) begin
            phase_left = cbs_pkg::PHASE_AFIB_BASE + cbs_pkg::PHASE_W'(offset);
         end else if (vpc_on) begin
            ptr = next_slot();
            if (store[ptr]) begin
               vpc_pending = run_len;
               phase_left  = cbs_pkg::PHASE_VPC_GAP;
            end else begin
               phase_left = cbs_pkg::PHASE_SINUS;
            end
         end else begin
            phase_left = cbs_pkg::PHASE_SINUS;
         end
         return cbs_pkg::EV_SINUS;
      endfunction

      function void note_beat(cbs_pkg::cmd_type cmd, logic cpr, logic shock,
                              logic [3:0] offset, logic [7:0] slot, logic pbit);
         cbs_pkg::event_type ev;
         rhythm_result_type  r;
         ev = cbs_pkg::EV_NONE;
         case (cmd)
            cbs_pkg::CMD_PULSE: begin
               if (!cpr && !shock) ev = pulse_tick(offset);
            end
            cbs_pkg::CMD_BREATH: begin
               if (!cpr && breath_on) begin
                  breath_cnt = breath_cnt + 1'b1;
                  ev = cbs_pkg::EV_BREATH;
               end
            end
            cbs_pkg::CMD_PATTERN: begin
               if (int'(slot) < cbs_pkg::PATTERN_LEN) store[slot] = pbit;
            end
            default: ;
         endcase
         r.ev     = ev;
         r.sinus  = sinus_cnt;
         r.vpc    = vpc_cnt;
         r.breath = breath_cnt;
         pending_q.push_back(r);
      endfunction

      task report(string msg);
         $display("%0t mismatch: %s", $time, msg);
         mismatches++;
      endtask

      task check_result(cbs_pkg::event_type ev, logic [cbs_pkg::CNT_W-1:0] sinus,
                        logic [cbs_pkg::CNT_W-1:0] vpc, logic [cbs_pkg::CNT_W-1:0] breath);
         rhythm_result_type want;
         if (pending_q.size() == 0) begin
            report($sformatf("result beat with none pending, event %0d", ev));
            return;
         end
         want = pending_q.pop_front();
         if (ev !== want.ev)
            report($sformatf("event got %0d want %0d", ev, want.ev));
         if (sinus !== want.sinus)
            report($sformatf("sinus_total got %0d want %0d", sinus, want.sinus));
         if (vpc !== want.vpc)
            report($sformatf("vpc_total got %0d want %0d", vpc, want.vpc));
         if (breath !== want.breath)
            report($sformatf("breath_total got %0d want %0d", breath, want.breath));
      endtask
   endclass

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [15:0]                req_tdata  = '0;
   logic [1:0]                 req_tuser  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [95:0]                rsp_tdata;
   logic [1:0]                 rsp_tuser;
   logic                       csr_we     = 1'b0;
   logic [cbs_pkg::CSR_AW-1:0] csr_addr   = '0;
   logic [cbs_pkg::CSR_DW-1:0] csr_wdata  = '0;

   int                send_idle_pct = 22;
   int                recv_idle_pct = 77;
   int unsigned       cycle_count;
   rhythm_scoreboard  sb = new();

   cardiac_beat_sequencer_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("cardiac_beat_sequencer_core_tb: FAIL");
      $finish;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(cbs_pkg::event_type'(rsp_tuser), rsp_tdata[31:0],
                         rsp_tdata[63:32], rsp_tdata[95:64]);
   end

   task send_beat(cbs_pkg::cmd_type cmd, logic cpr, logic shock, logic [3:0] offset,
                  logic [7:0] slot, logic pbit);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {1'b0, pbit, slot, offset, shock, cpr};
      do @(posedge clock); while (!req_tready);
      sb.note_beat(cmd, cpr, shock, offset, slot, pbit);
      @(negedge clock);
   endtask

   task send_random(int pulse_pct, int one_pct);
      cbs_pkg::cmd_type cmd;
      logic [7:0]       slot;
      if ($urandom_range(99) < pulse_pct) begin
         cmd = cbs_pkg::CMD_PULSE;
      end else begin
         case ($urandom_range(5))
            0, 1:    cmd = cbs_pkg::CMD_BREATH;
            2, 3, 4: cmd = cbs_pkg::CMD_PATTERN;
            default: cmd = cbs_pkg::CMD_SPARE;
         endcase
      end
      // aim half the writes at the entry the next sinus beat reads
      slot = $urandom_range(1) ? 8'($urandom_range(255)) : 8'(sb.next_slot());
      send_beat(cmd, $urandom_range(99) < 8, $urandom_range(99) < 8, 4'($urandom_range(15)),
                slot, $urandom_range(99) < one_pct);
   endtask

   task wait_idle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (sb.pending_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task write_csr(cbs_pkg::csr_index_type idx, logic [cbs_pkg::CSR_DW-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      sb.set_reg(idx, val);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task apply_setting(logic pulse, logic breath, logic vpc, logic [cbs_pkg::VPC_W-1:0] run,
                      logic afib);
      wait_idle();
      write_csr(cbs_pkg::CSR_PULSE_ACTIVE, cbs_pkg::CSR_DW'(pulse));
      write_csr(cbs_pkg::CSR_BREATH_ACTIVE, cbs_pkg::CSR_DW'(breath));
      write_csr(cbs_pkg::CSR_VPC_ENABLE, cbs_pkg::CSR_DW'(vpc));
      write_csr(cbs_pkg::CSR_VPC_RUN_LEN, cbs_pkg::CSR_DW'(run));
      write_csr(cbs_pkg::CSR_AFIB_MODE, cbs_pkg::CSR_DW'(afib));
   endtask

   task run_phase(int per_setting);
      for (int k = 0; k < 5; k++) begin
         case (k)
            0: apply_setting(1'b1, 1'b1, 1'b1, 2'd3, 1'b0);
            1: apply_setting(1'b1, 1'b0, 1'b1, 2'd0, 1'b0);
            2: apply_setting(1'b1, 1'b1, 1'b1, 2'd3, 1'b1);
            3: apply_setting(1'b0, 1'b0, 1'b0, 2'd0, 1'b0);
            default: apply_setting($urandom_range(99) < 80, 1'($urandom_range(1)),
                                   1'($urandom_range(1)), 2'($urandom_range(3)),
                                   1'($urandom_range(1)));
         endcase
         repeat (per_setting) send_random(70, 50);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // registers still at reset: ticks do nothing
      send_beat(cbs_pkg::CMD_PULSE, 1'b0, 1'b0, 4'd15, 8'd255, 1'b1);
      send_beat(cbs_pkg::CMD_BREATH, 1'b0, 1'b0, 4'd0, 8'd0, 1'b0);

      apply_setting(1'b1, 1'b1, 1'b1, 2'd3, 1'b0);
      send_beat(cbs_pkg::CMD_PATTERN, 1'b1, 1'b1, 4'd0, 8'd1, 1'b1);
      send_beat(cbs_pkg::CMD_PATTERN, 1'b0, 1'b0, 4'd15, 8'd255, 1'b1);
      send_beat(cbs_pkg::CMD_PATTERN, 1'b0, 1'b0, 4'd0, 8'd0, 1'b0);
      send_beat(cbs_pkg::CMD_SPARE, 1'b1, 1'b1, 4'd15, 8'd255, 1'b1);
      send_beat(cbs_pkg::CMD_PULSE, 1'b1, 1'b0, 4'd0, 8'd0, 1'b0);
      send_beat(cbs_pkg::CMD_PULSE, 1'b0, 1'b1, 4'd0, 8'd0, 1'b0);
      send_beat(cbs_pkg::CMD_BREATH, 1'b0, 1'b1, 4'd0, 8'd0, 1'b0);
      send_beat(cbs_pkg::CMD_BREATH, 1'b1, 1'b0, 4'd0, 8'd0, 1'b0);
      // expiry from reset: sinus beat, entry one launches a run
      send_beat(cbs_pkg::CMD_PULSE, 1'b0, 1'b0, 4'd0, 8'd0, 1'b0);
      repeat (14) send_beat(cbs_pkg::CMD_PULSE, 1'b0, 1'b0, 4'($urandom_range(15)),
                            8'd0, 1'b0);

      run_phase(80);

      wait_idle();
      send_idle_pct = 77;
      recv_idle_pct = 22;
      run_phase(80);

      wait_idle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(80);

      // long pulse run with VPC run length zero, so no new VPC runs are launched
      apply_setting(1'b1, 1'b1, 1'b1, 2'd0, 1'b0);
      repeat (520) send_random(92, 80);

      wait_idle();
      repeat (20) @(negedge clock);
      if (sb.mismatches == 0) begin
         $display("cardiac_beat_sequencer_core_tb: PASS");
      end else begin
         $display("cardiac_beat_sequencer_core_tb: FAIL");
      end
      $finish;
   end

endmodule
